>>> rtl/sacl_pkg.sv
// Shared types and constants for the set-associative cache tag store.
// No dependencies; used by the top module and the testbench.
package sacl_pkg;

  localparam logic POLICY_LRU  = 1'b0;
  localparam logic POLICY_FIFO = 1'b1;

  typedef struct packed {
    logic [31:0] address;
    logic        write_op;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  way_used;
    logic        evicted;
    logic        evicted_dirty;
    logic [19:0] evicted_tag;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } out_t;

endpackage

>>> rtl/sacl_tag_ram.sv
// Single-port-write, single-port-read line store (tag and stamps).
// Read data registered. No dependencies.
module sacl_tag_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 84
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/set_assoc_cache_tag_lru_fifo_top.sv
// Tag store of a set-associative cache with LRU or FIFO replacement.
// A transaction runs through the states SCAN, WRITE and OUT to result valid; the
// ways of the set are read one per cycle from the line RAM, then at most one write.
// No new transaction is accepted until the result of the last one is taken.
// Reset (rst_n low, synchronous): valid/dirty bits, timer, counters, policy cleared.
// Depends on sacl_pkg and sacl_tag_ram.
module set_assoc_cache_tag_lru_fifo_top #(
  parameter int OFFSET_BITS = 6,
  parameter int SET_BITS    = 6,
  parameter int WAYS        = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  sacl_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output sacl_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic            cfg_wdata
);

  localparam int SET_COUNT = 1 << SET_BITS;
  localparam int LINES    = SET_COUNT * WAYS;
  localparam int LB       = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int WB       = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CB       = $clog2(WAYS + 1);
  localparam int TW       = 32 - OFFSET_BITS - SET_BITS;
  localparam int DW       = TW + 64;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  logic            policy_r;
  logic [31:0]     clock_r, hits_r, misses_r;
  logic [LINES-1:0] valid_r, dirty_r;
  logic [TW-1:0]   req_tag_r;
  logic            req_wr_r;
  logic [LB-1:0]   base_r;
  logic [CB-1:0]   cnt_r;
  logic            hit_r, inv_r;
  logic [WB-1:0]   hit_way_r, inv_way_r, best_way_r;
  logic [31:0]     hit_ins_r, best_r;
  logic [TW-1:0]   best_tag_r;
  sacl_pkg::out_t  out_r;

  logic            ram_we;
  logic [LB-1:0]   ram_waddr, ram_raddr;
  logic [DW-1:0]   ram_wdata, ram_rdata;

  logic [TW-1:0]   rd_tag;
  logic [31:0]     rd_ins, rd_use, rd_stamp;
  logic [WB-1:0]   cur_way, fin_way;
  logic [LB-1:0]   cur_line, fin_line;
  logic [31:0]     set_idx;

  assign rd_tag   = ram_rdata[DW-1 -: TW];
  assign rd_ins   = ram_rdata[63:32];
  assign rd_use   = ram_rdata[31:0];
  assign rd_stamp = (policy_r == sacl_pkg::POLICY_FIFO) ? rd_ins : rd_use;
  assign cur_way  = WB'(cnt_r - CB'(1));
  assign cur_line = base_r + LB'(cur_way);
  assign fin_way  = hit_r ? hit_way_r : (inv_r ? inv_way_r : best_way_r);
  assign fin_line = base_r + LB'(fin_way);
  assign set_idx  = (in_data.address >> OFFSET_BITS) & 32'(SET_COUNT - 1);

  assign ram_raddr = base_r + LB'(cnt_r);
  assign ram_waddr = fin_line;
  assign ram_we    = (state_r == S_WRITE) &&
                     (!hit_r || policy_r == sacl_pkg::POLICY_LRU);
  assign ram_wdata = hit_r ? {req_tag_r, hit_ins_r, clock_r}
                           : {req_tag_r, clock_r, clock_r};

  sacl_tag_ram #(.DEPTH(LINES), .AW(LB), .DW(DW)) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SCAN;
      S_SCAN:  if (cnt_r == CB'(WAYS)) state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_OUT;
      S_OUT:   if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      policy_r <= sacl_pkg::POLICY_LRU;
      clock_r  <= '0;
      hits_r   <= '0;
      misses_r <= '0;
      valid_r  <= '0;
      dirty_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        policy_r <= cfg_wdata;
      end
      if (state_r == S_IDLE && in_valid) begin
        clock_r <= clock_r + 32'd1;
      end
      if (state_r == S_WRITE) begin
        if (hit_r) begin
          hits_r <= hits_r + 32'd1;
          if (req_wr_r) dirty_r[fin_line] <= 1'b1;
        end else begin
          misses_r <= misses_r + 32'd1;
          valid_r[fin_line] <= 1'b1;
          dirty_r[fin_line] <= req_wr_r;
        end
      end
    end
  end

  // scan datapath: one way per cycle; the registered read data belongs to the previous address
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      req_tag_r <= TW'(in_data.address >> (OFFSET_BITS + SET_BITS));
      req_wr_r  <= in_data.write_op;
      base_r    <= LB'(set_idx * 32'(WAYS));
      cnt_r     <= '0;
      hit_r     <= 1'b0;
      inv_r     <= 1'b0;
    end else if (state_r == S_SCAN) begin
      cnt_r <= cnt_r + CB'(1);
      if (cnt_r != '0) begin
        if (valid_r[cur_line] && rd_tag == req_tag_r && !hit_r) begin
          hit_r     <= 1'b1;
          hit_way_r <= cur_way;
          hit_ins_r <= rd_ins;
        end
        if (!valid_r[cur_line] && !inv_r) begin
          inv_r     <= 1'b1;
          inv_way_r <= cur_way;
        end
        if (cur_way == '0 || rd_stamp < best_r) begin
          best_r     <= rd_stamp;
          best_way_r <= cur_way;
          best_tag_r <= rd_tag;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) begin
      out_r.hit        <= hit_r;
      out_r.way_used   <= 2'(fin_way);
      out_r.evicted    <= !hit_r && !inv_r;
      out_r.evicted_dirty <= !hit_r && !inv_r && dirty_r[fin_line];
      out_r.evicted_tag   <= (!hit_r && !inv_r) ? 20'(best_tag_r) : 20'd0;
      out_r.hit_total  <= hit_r ? hits_r + 32'd1 : hits_r;
      out_r.miss_total <= hit_r ? misses_r : misses_r + 32'd1;
    end
  end

endmodule

>>> dv/set_assoc_cache_tag_lru_fifo_top_tb.sv
// Testbench for the cache tag store: drives address/read-write transactions,
// predicts hit, way and eviction per access for LRU and FIFO policies.
// Depends on sacl_pkg and set_assoc_cache_tag_lru_fifo_top.
module set_assoc_cache_tag_lru_fifo_top_tb;

  localparam int OFS = 6;
  localparam int SETB = 6;
  localparam int NWAY = 4;
  localparam int NSET = 1 << SETB;
  localparam int TAGB = 32 - OFS - SETB;

  class tag_store_scoreboard;
    logic [31-OFS-SETB:0] tag_q [NSET][NWAY];
    bit valid_q [NSET][NWAY];
    bit dirty_q [NSET][NWAY];
    logic [31:0] ins_stamp [NSET][NWAY];
    logic [31:0] use_stamp_q [NSET][NWAY];
    logic [31:0] tick, hits, misses;
    bit fifo_mode;
    sacl_pkg::out_t pending[$];
    int errors;

    function void clear();
      foreach (valid_q[s, w]) begin
        valid_q[s][w] = 0;
        dirty_q[s][w] = 0;
      end
      tick = 0;
      hits = 0;
      misses = 0;
      fifo_mode = sacl_pkg::POLICY_LRU;
      errors = 0;
      pending.delete();
    endfunction

    function void note_access(sacl_pkg::in_t t);
      sacl_pkg::out_t r;
      int s, w, pick;
      logic [31-OFS-SETB:0] tg;
      logic [31:0] best, m;
      bit found;
      s = int'(t.address[OFS+SETB-1:OFS]);
      tg = t.address[31:OFS+SETB];
      r = '0;
      found = 0;
      pick = 0;
      tick++;
      for (w = 0; w < NWAY; w++)
        if (!found && valid_q[s][w] && tag_q[s][w] == tg) begin
          found = 1;
          pick = w;
        end
      if (found) begin
        hits++;
        r.hit = 1;
        if (fifo_mode == sacl_pkg::POLICY_LRU) use_stamp_q[s][pick] = tick;
        if (t.write_op) dirty_q[s][pick] = 1;
      end else begin
        misses++;
        for (w = NWAY - 1; w >= 0; w--)
          if (!valid_q[s][w]) begin
            found = 1;
            pick = w;
          end
        if (!found) begin
          // oldest stamp wins, ties to the lowest way
          pick = 0;
          best = fifo_mode ? ins_stamp[s][0] : use_stamp_q[s][0];
          for (w = 1; w < NWAY; w++) begin
            m = fifo_mode ? ins_stamp[s][w] : use_stamp_q[s][w];
            if (m < best) begin
              best = m;
              pick = w;
            end
          end
          r.evicted = 1;
          r.evicted_dirty = dirty_q[s][pick];
          r.evicted_tag = tag_q[s][pick][19:0];
        end
        tag_q[s][pick] = tg;
        valid_q[s][pick] = 1;
        dirty_q[s][pick] = t.write_op;
        ins_stamp[s][pick] = tick;
        use_stamp_q[s][pick] = tick;
      end
      r.way_used = pick[1:0];
      r.hit_total = hits;
      r.miss_total = misses;
      pending.push_back(r);
    endfunction

    function void check_result(sacl_pkg::out_t got);
      sacl_pkg::out_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.hit !== exp.hit || got.way_used !== exp.way_used ||
          got.evicted !== exp.evicted || got.evicted_dirty !== exp.evicted_dirty ||
          got.evicted_tag !== exp.evicted_tag || got.hit_total !== exp.hit_total ||
          got.miss_total !== exp.miss_total) begin
        $display("%0t: mismatch expected %p actual %p", $time, exp, got);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  sacl_pkg::in_t in_data;
  sacl_pkg::out_t out_data;
  logic cfg_we, cfg_wdata;

  tag_store_scoreboard sb;
  bit idle_off;
  int rx_hold_cycles;

  set_assoc_cache_tag_lru_fifo_top #(.OFFSET_BITS(OFS), .SET_BITS(SETB), .WAYS(NWAY)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("set_assoc_cache_tag_lru_fifo_top verification failed");
    $finish;
  end

  // receiver: random stall, with a long hold-off on request
  initial begin
    out_stall = 1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_stall <= 1;
      end else
        out_stall <= (!idle_off && $urandom_range(99) < 25);
      @(posedge clk);
    end
  end

  // valid stays high after acceptance until the next call drives or drops it
  task automatic send(input logic [31:0] addr, input bit wr);
    sacl_pkg::in_t t;
    while (!idle_off && $urandom_range(99) < 25) begin
      in_valid <= 0;
      @(posedge clk);
    end
    t.address = addr;
    t.write_op = wr;
    in_valid <= 1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_access(t);
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    while (n < 3 * NWAY + 10) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic set_policy(input bit fifo);
    drain();
    cfg_we <= 1;
    cfg_wdata <= fifo;
    @(posedge clk);
    cfg_we <= 0;
    sb.fifo_mode = fifo;
  endtask

  // address from a set, a small tag pool and random offset
  function automatic logic [31:0] pool_addr(int setn, int tpool);
    logic [31:0] a;
    a = $urandom();
    a[OFS+SETB-1:OFS] = SETB'(setn);
    a[31:OFS+SETB] = TAGB'($urandom_range(tpool - 1));
    return a;
  endfunction

  initial begin
    int i, k;
    sb = new();
    sb.clear();
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_wdata = 0;
    idle_off = 0;
    rx_hold_cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, fill a set, hit, evict dirty and clean
    send(32'h0000_0000, 0);
    send(32'hFFFF_FFFF, 1);
    send(32'h0000_0000, 1);
    for (k = 1; k < 6; k++) send({k[19:0], 6'd0, 6'h3F} , k[0]);
    send(32'hFFFF_FFC0, 0);
    send(32'h0000_0000, 0);
    for (k = 0; k < 6; k++) send({k[19:0] + 20'h80000, 6'd5, 6'd0}, 1);
    set_policy(sacl_pkg::POLICY_FIFO);
    for (k = 0; k < 6; k++) send({k[19:0], 6'd9, 6'd1}, 0);
    send({20'd0, 6'd9, 6'd2}, 1);
    send({20'd7, 6'd9, 6'd2}, 0);

    for (i = 0; i < 1900; i++) begin
      if (i == 300) begin
        set_policy(sacl_pkg::POLICY_LRU);
        idle_off = 1;
      end
      if (i == 500) idle_off = 0;
      if (i == 700) rx_hold_cycles = 200;
      if (i == 900) set_policy(sacl_pkg::POLICY_FIFO);
      if (i == 1200) drain();
      if (i == 1500) set_policy(sacl_pkg::POLICY_LRU);
      if (i < 1700)
        send(pool_addr(int'($urandom_range(3)), 7), 1'($urandom_range(1)));
      else
        send($urandom(), 1'($urandom_range(1)));
    end
    drain();
    if (sb.errors == 0)
      $display("set_assoc_cache_tag_lru_fifo_top verification clean");
    else
      $display("set_assoc_cache_tag_lru_fifo_top verification failed");
    $finish;
  end
endmodule

>>> files.f
rtl/sacl_pkg.sv
rtl/sacl_tag_ram.sv
rtl/set_assoc_cache_tag_lru_fifo_top.sv
dv/set_assoc_cache_tag_lru_fifo_top_tb.sv
